// ----- rtl/core/nnd_pkg.sv -----
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared sizes, configuration codes and helper functions of the
// nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package nnd_pkg;

	// Largest supported frame dimension
	localparam int MAX_DIM = 2048;

	// Width of a clamped size or of a row count that may reach MAX_DIM
	localparam int DIM_W = $clog2(MAX_DIM) + 1;
	// Width of a position below MAX_DIM
	localparam int POS_W = $clog2(MAX_DIM);
	// Width of a running sum position * size
	localparam int SUM_W = 2 * POS_W;

	// Configuration register widths
	localparam int IN_SIZE_W  = 12;
	localparam int OUT_SIZE_W = 11;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;

	// Pixel sample width
	localparam int PIX_W = 8;

	// Register reset values
	localparam int IN_WIDTH_RST   = 176;
	localparam int IN_HEIGHT_RST  = 144;
	localparam int OUT_WIDTH_RST  = 96;
	localparam int OUT_HEIGHT_RST = 96;

	// Luma weights in thousandths, sum width and divide-by-1000 reciprocal
	localparam int LUMA_R  = 299;
	localparam int LUMA_G  = 587;
	localparam int LUMA_B  = 114;
	localparam int LUMA_W  = 18;
	localparam int RECIP_W = 19;
	localparam int RECIP_SH = 28;
	// ceil(2^28 / 1000), exact for every weighted sum up to 255000
	localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_WIDTH   = 3'd0,
		CFG_IN_HEIGHT  = 3'd1,
		CFG_OUT_WIDTH  = 3'd2,
		CFG_OUT_HEIGHT = 3'd3,
		CFG_COLOR_MODE = 3'd4
	} cfg_idx_t;

	// Clamp a source size to [2, MAX_DIM]
	function automatic logic [DIM_W-1:0] clamp_in(input logic [IN_SIZE_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (32'(v) < 2) begin
			r = DIM_W'(2);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	// Clamp an output size to [1, in_eff - 1]
	function automatic logic [DIM_W-1:0] clamp_out(input logic [OUT_SIZE_W-1:0] v,
			input logic [DIM_W-1:0] in_eff);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(in_eff) - 1) begin
			r = in_eff - DIM_W'(1);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/nnd_if.sv -----
// ----------------------------------------------------------------------------
// nnd_if
// Valid/ready channels of the downscaler: source pixels, kept pixels and
// configuration writes.
// ----------------------------------------------------------------------------

// Source pixel channel
interface nnd_pix_if;
	logic                      valid;
	logic                      ready;
	logic                      start_frame;
	logic [nnd_pkg::PIX_W-1:0] sample_a;
	logic [nnd_pkg::PIX_W-1:0] sample_b;
	logic [nnd_pkg::PIX_W-1:0] sample_c;

	modport source (output valid, start_frame, sample_a, sample_b, sample_c, input ready);
	modport sink (input valid, start_frame, sample_a, sample_b, sample_c, output ready);
endinterface

// Kept pixel channel
interface nnd_res_if;
	logic                      valid;
	logic                      ready;
	logic [nnd_pkg::PIX_W-1:0] out_pixel;
	logic                      last_of_frame;

	modport source (output valid, out_pixel, last_of_frame, input ready);
	modport sink (input valid, out_pixel, last_of_frame, output ready);
endinterface

// Configuration write channel
interface nnd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [nnd_pkg::CFG_IDX_W-1:0]  index;
	logic [nnd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/nearest_neighbor_downscaler.sv -----
// Path: a kept pixel passes stage 1, stage 2 and the stage 3 output register.
// Throughput: one source item per cycle while the output is not stalled; the
// column/row counter update of stage 1 is combinational, so items follow back to back.
// Stalls on the output fill the three stages before the input is held off.
// Reset: configuration returns to 176x144 -> 96x96 gray, counters clear and
// the zero state acts as a frame start; all stages empty.
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// Nearest-neighbor frame downscaler for a raster pixel stream with optional
// RGB to gray conversion of the kept pixels.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler (
	input  logic     clk,
	input  logic     arst_n,
	nnd_pix_if.sink  pix_in,
	nnd_res_if.source res_out,
	nnd_cfg_if.sink  cfg
);

	localparam int DIM_W = nnd_pkg::DIM_W;
	localparam int POS_W = nnd_pkg::POS_W;
	localparam int SUM_W = nnd_pkg::SUM_W;
	localparam int PIX_W = nnd_pkg::PIX_W;
	localparam int LUMA_W = nnd_pkg::LUMA_W;
	localparam int PROD_W = nnd_pkg::LUMA_W + nnd_pkg::RECIP_W;

	// Configuration registers
	logic [nnd_pkg::IN_SIZE_W-1:0]  in_width_q, in_height_q;
	logic [nnd_pkg::OUT_SIZE_W-1:0] out_width_q, out_height_q;
	logic                           color_mode_q;

	// Frame counters
	logic [POS_W-1:0] src_col_q, dst_col_q, dst_row_q;
	logic [DIM_W-1:0] src_row_q;
	logic [SUM_W-1:0] col_scaled_q, row_scaled_q, col_target_q, row_target_q;

	// Pipeline stages
	logic             v_s1, start_s1;
	logic [PIX_W-1:0] a_s1, b_s1, c_s1;
	logic             v_s2, color_s2, last_s2;
	logic [PIX_W-1:0] gray_s2;
	logic [LUMA_W-1:0] luma_s2;
	logic             v_s3, last_s3;
	logic [PIX_W-1:0] pix_s3;

	// Combinational signals
	logic             load_1, load_2, load_3, advance;
	logic [DIM_W-1:0] iw, ih, ow, oh;
	logic [POS_W-1:0] cur_src_col, cur_dst_col, cur_dst_row;
	logic [DIM_W-1:0] cur_src_row;
	logic [SUM_W-1:0] cur_col_scaled, cur_row_scaled, cur_col_target, cur_row_target;
	logic [POS_W-1:0] nxt_src_col, nxt_dst_col, nxt_dst_row;
	logic [DIM_W-1:0] nxt_src_row;
	logic [SUM_W-1:0] nxt_col_scaled, nxt_row_scaled, nxt_col_target, nxt_row_target;
	logic             frame_done, row_hit, col_hit, line_end, keep, last_pix;
	logic [LUMA_W-1:0] luma;
	logic [PROD_W-1:0] luma_prod;

	// Configuration writes, always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= nnd_pkg::IN_SIZE_W'(nnd_pkg::IN_WIDTH_RST);
			in_height_q  <= nnd_pkg::IN_SIZE_W'(nnd_pkg::IN_HEIGHT_RST);
			out_width_q  <= nnd_pkg::OUT_SIZE_W'(nnd_pkg::OUT_WIDTH_RST);
			out_height_q <= nnd_pkg::OUT_SIZE_W'(nnd_pkg::OUT_HEIGHT_RST);
			color_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				nnd_pkg::CFG_IN_WIDTH:   in_width_q   <= cfg.data[nnd_pkg::IN_SIZE_W-1:0];
				nnd_pkg::CFG_IN_HEIGHT:  in_height_q  <= cfg.data[nnd_pkg::IN_SIZE_W-1:0];
				nnd_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg.data[nnd_pkg::OUT_SIZE_W-1:0];
				nnd_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg.data[nnd_pkg::OUT_SIZE_W-1:0];
				nnd_pkg::CFG_COLOR_MODE: color_mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Effective sizes
	assign iw = nnd_pkg::clamp_in(in_width_q);
	assign ih = nnd_pkg::clamp_in(in_height_q);
	assign ow = nnd_pkg::clamp_out(out_width_q, iw);
	assign oh = nnd_pkg::clamp_out(out_height_q, ih);

	// Stage handshakes: a stage loads when empty or when it drains
	assign load_3 = !v_s3 || res_out.ready;
	assign load_2 = !v_s2 || load_3;
	assign load_1 = !v_s1 || load_2;
	assign advance = v_s1 && load_2;
	assign pix_in.ready = load_1;

	// Counters as seen by the item in stage 1, cleared on a frame start
	always_comb begin
		if (start_s1) begin
			cur_src_col    = '0;
			cur_src_row    = '0;
			cur_dst_col    = '0;
			cur_dst_row    = '0;
			cur_col_scaled = '0;
			cur_row_scaled = '0;
			cur_col_target = '0;
			cur_row_target = '0;
		end else begin
			cur_src_col    = src_col_q;
			cur_src_row    = src_row_q;
			cur_dst_col    = dst_col_q;
			cur_dst_row    = dst_row_q;
			cur_col_scaled = col_scaled_q;
			cur_row_scaled = row_scaled_q;
			cur_col_target = col_target_q;
			cur_row_target = row_target_q;
		end
	end

	// Selection tests
	always_comb begin
		frame_done = cur_src_row >= ih;
		row_hit = (DIM_W'(cur_dst_row) < oh) && (cur_row_scaled <= cur_row_target) &&
			({1'b0, cur_row_target} < {1'b0, cur_row_scaled} + (SUM_W+1)'(oh));
		col_hit = (DIM_W'(cur_dst_col) < ow) && (cur_col_scaled <= cur_col_target) &&
			({1'b0, cur_col_target} < {1'b0, cur_col_scaled} + (SUM_W+1)'(ow));
		line_end = DIM_W'(cur_src_col) >= iw - DIM_W'(1);
		keep = !frame_done && row_hit && col_hit;
		last_pix = (DIM_W'(cur_dst_row) == oh - DIM_W'(1)) &&
			(DIM_W'(cur_dst_col) == ow - DIM_W'(1));
	end

	// Counter update for one source pixel
	always_comb begin
		nxt_src_col    = cur_src_col;
		nxt_src_row    = cur_src_row;
		nxt_dst_col    = cur_dst_col;
		nxt_dst_row    = cur_dst_row;
		nxt_col_scaled = cur_col_scaled;
		nxt_row_scaled = cur_row_scaled;
		nxt_col_target = cur_col_target;
		nxt_row_target = cur_row_target;
		if (!frame_done) begin
			if (col_hit) begin
				nxt_dst_col    = cur_dst_col + POS_W'(1);
				nxt_col_target = cur_col_target + SUM_W'(iw - DIM_W'(1));
			end
			if (line_end) begin
				if (row_hit) begin
					nxt_dst_row    = cur_dst_row + POS_W'(1);
					nxt_row_target = cur_row_target + SUM_W'(ih - DIM_W'(1));
				end
				nxt_src_row    = cur_src_row + DIM_W'(1);
				nxt_row_scaled = cur_row_scaled + SUM_W'(oh);
				nxt_src_col    = '0;
				nxt_col_scaled = '0;
				nxt_dst_col    = '0;
				nxt_col_target = '0;
			end else begin
				nxt_src_col    = cur_src_col + POS_W'(1);
				nxt_col_scaled = cur_col_scaled + SUM_W'(ow);
			end
		end
	end

	// Advance counters when the stage 1 item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q    <= '0;
			src_row_q    <= '0;
			dst_col_q    <= '0;
			dst_row_q    <= '0;
			col_scaled_q <= '0;
			row_scaled_q <= '0;
			col_target_q <= '0;
			row_target_q <= '0;
		end else if (advance) begin
			src_col_q    <= nxt_src_col;
			src_row_q    <= nxt_src_row;
			dst_col_q    <= nxt_dst_col;
			dst_row_q    <= nxt_dst_row;
			col_scaled_q <= nxt_col_scaled;
			row_scaled_q <= nxt_row_scaled;
			col_target_q <= nxt_col_target;
			row_target_q <= nxt_row_target;
		end
	end

	// Stage 1: capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_1) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_1 && pix_in.valid) begin
			start_s1 <= pix_in.start_frame;
			a_s1     <= pix_in.sample_a;
			b_s1     <= pix_in.sample_b;
			c_s1     <= pix_in.sample_c;
		end
	end

	// Weighted RGB sum in thousandths
	assign luma = LUMA_W'(a_s1) * LUMA_W'(nnd_pkg::LUMA_R) +
		LUMA_W'(b_s1) * LUMA_W'(nnd_pkg::LUMA_G) +
		LUMA_W'(c_s1) * LUMA_W'(nnd_pkg::LUMA_B);

	// Stage 2: hold kept pixels only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_2) begin
			v_s2 <= v_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			color_s2 <= color_mode_q;
			last_s2  <= last_pix;
			gray_s2  <= a_s1;
			luma_s2  <= luma;
		end
	end

	// Divide by 1000 through the reciprocal
	assign luma_prod = PROD_W'(luma_s2) * PROD_W'(nnd_pkg::RECIP_1000);

	// Stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (load_3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_3 && v_s2) begin
			last_s3 <= last_s2;
			pix_s3  <= color_s2 ? luma_prod[nnd_pkg::RECIP_SH +: PIX_W] : gray_s2;
		end
	end

	assign res_out.valid         = v_s3;
	assign res_out.out_pixel     = pix_s3;
	assign res_out.last_of_frame = last_s3;

	// Input is held off only when every stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (v_s1 && v_s2 && v_s3))
		else $error("input stalled with an empty stage");

	// A kept pixel only appears out of an occupied stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1))
		else $error("stage 2 filled without a stage 1 item");

	// Row count stops at the frame height, so it stays within MAX_DIM
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(src_row_q) <= nnd_pkg::MAX_DIM)
		else $error("source row count ran past the largest frame");

endmodule
